/* rtl/spq_pkg.sv */
// Package: sizes, word types and codes for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
  localparam int IDX_BITS     = $clog2(CAPACITY);

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    op_t                     op;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [KEY_BITS-1:0]     head_key;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [KEY_BITS-1:0]     tail_key;
    logic [PAYLOAD_BITS-1:0] tail_payload;
    logic [COUNT_BITS-1:0]   entry_count;
  } out_word_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic occ;
    logic left_le;
  } cell_ctrl_t;

endpackage

/* rtl/stable_sorted_priority_queue_top.sv */
// Top level: stable sorted priority queue built as a chain of slot cells.
//
// Command channel: a word (op, key, payload) is taken at a rising edge with
// start high and busy low. busy stays low, so one command per cycle is taken.
// Enqueue places the entry after all stored entries with key less or equal;
// dequeue removes the front entry. Full enqueue and empty dequeue set the
// status and leave the queue as it was.
// Result channel: one result word per command, on result for one cycle with
// done high, in the cycle after the command edge.
// Each slot compares its key with the incoming key in parallel and moves
// data one place in the same edge, so the cell chain sets the rate.
// The receiver cannot hold results off; none are needed since busy is low.
// Reset clears the entry count and done; slot contents are left as they are
// and are only looked at below the count.
module stable_sorted_priority_queue_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spq_pkg::in_word_t     cmd,
  output logic                  done,
  output spq_pkg::out_word_t    result
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::COUNT_BITS-1:0] count, count_next;
  logic                           go, enq_ok, deq_ok;
  spq_pkg::entry_t                new_entry;
  spq_pkg::entry_t                slot      [N];
  spq_pkg::entry_t                slot_next [N];
  logic [N-1:0]                   le;
  logic [spq_pkg::IDX_BITS-1:0]   tail_idx;
  spq_pkg::out_word_t             result_next;

  assign busy      = 1'b0;
  assign go        = start && !busy;
  assign enq_ok    = go && (cmd.op == spq_pkg::OP_ENQ) &&
                     (count < spq_pkg::COUNT_BITS'(N));
  assign deq_ok    = go && (cmd.op == spq_pkg::OP_DEQ) && (count != '0);
  assign new_entry = '{key: cmd.key, payload: cmd.payload};

  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     left_e, right_e;

    assign ctrl.enq     = enq_ok;
    assign ctrl.deq     = deq_ok;
    assign ctrl.occ     = spq_pkg::COUNT_BITS'(i) < count;
    if (i == 0) begin : g_first
      assign ctrl.left_le = 1'b1;
      assign left_e       = new_entry;
    end else begin : g_mid
      assign ctrl.left_le = le[i-1];
      assign left_e       = slot[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_e = new_entry;
    end else begin : g_inner
      assign right_e = slot[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (slot[i]),
      .entry_next  (slot_next[i]),
      .le          (le[i])
    );
  end

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
    end
  end

  assign tail_idx = spq_pkg::IDX_BITS'(count_next - 1'b1);

  always_comb begin
    result_next = '0;
    if (go && (cmd.op == spq_pkg::OP_ENQ) && !enq_ok) begin
      result_next.status = spq_pkg::ST_FULL;
    end else if (go && (cmd.op == spq_pkg::OP_DEQ) && !deq_ok) begin
      result_next.status = spq_pkg::ST_EMPTY;
    end else begin
      result_next.status = spq_pkg::ST_OK;
    end
    if (deq_ok) begin
      result_next.out_key     = slot[0].key;
      result_next.out_payload = slot[0].payload;
    end
    if (count_next != '0) begin
      result_next.head_key     = slot_next[0].key;
      result_next.head_payload = slot_next[0].payload;
      result_next.tail_key     = slot_next[tail_idx].key;
      result_next.tail_payload = slot_next[tail_idx].payload;
    end
    result_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= go;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

/* rtl/spq_cell.sv */
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output spq_pkg::entry_t     entry_next,
  output logic                le
);

  assign le = ctrl.occ && (entry.key <= new_entry.key);

  always_comb begin
    entry_next = entry;
    if (ctrl.enq && !le) begin
      if (ctrl.left_le) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* test/spq_order_checker.sv */
// Checker for the sorted priority queue: predicts every result word and compares it.
module spq_order_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  spq_pkg::in_word_t  cmd,
  input  logic               done,
  input  spq_pkg::out_word_t result,
  output int                 mismatches,
  output int                 pending,
  output int                 words_checked,
  output int                 full_hits,
  output int                 empty_hits,
  output int                 deepest
);
  timeunit 1ns;
  timeprecision 1ps;

  spq_pkg::entry_t    slots [spq_pkg::CAPACITY];
  int                 depth;
  spq_pkg::out_word_t pending_results [$];

  function automatic spq_pkg::out_word_t queue_step(spq_pkg::in_word_t w);
    spq_pkg::out_word_t r;
    int                 pos;
    int                 i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (w.op == spq_pkg::OP_ENQ) begin
      if (depth >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < depth && slots[pos].key <= w.key) pos++;
        for (i = depth; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].key     = w.key;
        slots[pos].payload = w.payload;
        depth++;
      end
    end else begin
      if (depth == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.out_key     = slots[0].key;
        r.out_payload = slots[0].payload;
        for (i = 1; i < depth; i++) slots[i-1] = slots[i];
        depth--;
      end
    end
    if (depth > 0) begin
      r.head_key     = slots[0].key;
      r.head_payload = slots[0].payload;
      r.tail_key     = slots[depth-1].key;
      r.tail_payload = slots[depth-1].payload;
    end
    r.entry_count = depth[spq_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches    = 0;
    pending       = 0;
    words_checked = 0;
    full_hits     = 0;
    empty_hits    = 0;
    deepest       = 0;
    depth         = 0;
  end

  always @(posedge clk) begin
    spq_pkg::out_word_t want;
    if (rst) begin
      depth = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with nothing expected: %h", $realtime, result);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status",       32'(want.status),       32'(result.status));
          check_field("out_key",      32'(want.out_key),      32'(result.out_key));
          check_field("out_payload",  want.out_payload,       result.out_payload);
          check_field("head_key",     32'(want.head_key),     32'(result.head_key));
          check_field("head_payload", want.head_payload,      result.head_payload);
          check_field("tail_key",     32'(want.tail_key),     32'(result.tail_key));
          check_field("tail_payload", want.tail_payload,      result.tail_payload);
          check_field("entry_count",  32'(want.entry_count),  32'(result.entry_count));
          words_checked++;
        end
      end
      if (start && !busy) begin
        want = queue_step(cmd);
        if (want.status == spq_pkg::ST_FULL) full_hits++;
        if (want.status == spq_pkg::ST_EMPTY) empty_hits++;
        if (depth > deepest) deepest = depth;
        pending_results.push_back(want);
      end
    end
    pending = pending_results.size();
  end

endmodule

/* test/stable_sorted_priority_queue_top_tb.sv */
// Testbench top: drives enqueue/dequeue words into the queue and reports the verdict.
module stable_sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  spq_pkg::in_word_t  cmd;
  logic               done;
  spq_pkg::out_word_t result;

  int mismatches, pending, words_checked, full_hits, empty_hits, deepest;
  int sent_directed, sent_random;

  stable_sorted_priority_queue_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  spq_order_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .done          (done),
    .result        (result),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked),
    .full_hits     (full_hits),
    .empty_hits    (empty_hits),
    .deepest       (deepest)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic spq_pkg::in_word_t make_word(spq_pkg::op_t op, logic [15:0] key,
                                                  logic [31:0] payload);
    spq_pkg::in_word_t w;
    w.op      = op;
    w.key     = key;
    w.payload = payload;
    return w;
  endfunction

  function automatic spq_pkg::in_word_t random_word(int enq_pct);
    spq_pkg::in_word_t w;
    w.op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
    case ($urandom_range(3))
      0:       w.key = 16'($urandom_range(7));
      1:       w.key = 16'($urandom);
      2:       w.key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: w.key = 16'hFFF8 + 16'($urandom_range(7));
    endcase
    case ($urandom_range(15))
      0:       w.payload = 32'h0000_0000;
      1:       w.payload = 32'hFFFF_FFFF;
      default: w.payload = $urandom;
    endcase
    return w;
  endfunction

  // called right after a rising edge; returns at the edge that takes the word
  task automatic send_word(input spq_pkg::in_word_t w, input int idle_pct);
    logic stalled;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_directed(input spq_pkg::in_word_t w);
    send_word(w, 9);
    sent_directed++;
  endtask

  initial begin
    int idle_pct;
    int enq_pct;
    int burst_len;
    int burst_idle;
    int phase_sent;
    int guard;
    int i;
    sent_directed = 0;
    sent_random   = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty dequeue, extremes, equal keys in arrival order, ignored fields on dequeue
    send_directed(make_word(spq_pkg::OP_DEQ, 16'hFFFF, 32'hFFFF_FFFF));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0000, 32'h0000_0000));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0005, 32'hAAAA_0001));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0005, 32'hAAAA_0002));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0005, 32'hAAAA_0003));
    send_directed(make_word(spq_pkg::OP_DEQ, 16'h1234, 32'h5555_AAAA));
    // fill to capacity, then overflow
    for (i = 0; i < spq_pkg::CAPACITY - 5; i++)
      send_directed(make_word(spq_pkg::OP_ENQ, 16'h8000 >> i, 32'h0F0F_0000 + i));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0001, 32'hDEAD_0001));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'hFFFF, 32'hDEAD_0002));
    send_directed(make_word(spq_pkg::OP_DEQ, 16'h0000, 32'h0000_0000));
    send_directed(make_word(spq_pkg::OP_ENQ, 16'h0005, 32'hAAAA_0004));
    send_directed(make_word(spq_pkg::OP_DEQ, 16'hFFFF, 32'h0000_0000));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct   = (phase == 0) ? 9 : (phase == 1) ? 75 : 0;
      phase_sent = 0;
      while (phase_sent < 635) begin
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
        burst_len  = $urandom_range(4, 40);
        burst_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
        for (i = 0; i < burst_len; i++) begin
          send_word(random_word(enq_pct), burst_idle);
          phase_sent++;
          sent_random++;
        end
      end
    end
    start <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (pending != 0) begin
      $display("results still outstanding: %0d", pending);
      $display("RESULT: ERROR");
      $finish;
    end
    repeat (5) @(posedge clk);

    $display("Sent %0d words (%0d directed, %0d random) over three idle phases.",
             sent_directed + sent_random, sent_directed, sent_random);
    $display("Checked %0d results: %0d full enqueues, %0d empty dequeues,",
             words_checked, full_hits, empty_hits);
    $display("deepest %0d, %0d mismatches.", deepest, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
